FILE: design/btil_pkg.sv
// ----------------------------------------------------------------------------
// btil_pkg
// Shared types and constants for the binary trie IPv4 lookup block.
// ----------------------------------------------------------------------------
package btil_pkg;

  localparam int NODE_INDEX_BITS_DEF = 18;
  localparam int ADDRESS_BITS_DEF    = 32;

  localparam int INDEX_W   = 18;
  localparam int POINTER_W = 32;
  localparam int IP_W      = 32;
  localparam int NODE_W    = 2 * POINTER_W;
  localparam int CFG_W     = 32;
  localparam int RECB_W    = 3;

  localparam logic [CFG_W-1:0]  LEAF_BASE_RESET    = 32'd16776960;
  localparam logic [RECB_W-1:0] RECORD_BYTES_RESET = 3'd3;
  localparam logic [RECB_W-1:0] RECORD_BYTES_FULL  = 3'd4;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic CFG_LEAF_BASE    = 1'b0;
  localparam logic CFG_RECORD_BYTES = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic [INDEX_W-1:0]   node_index;
    logic [POINTER_W-1:0] left_pointer;
    logic [POINTER_W-1:0] right_pointer;
    logic [IP_W-1:0]      ip_address;
  } in_word_t;

  typedef struct packed {
    logic [POINTER_W-1:0] leaf_value;
    logic                 not_found;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic write_node;
    logic start;
    logic walk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic walk_end;
  } status_t;

endpackage

FILE: design/binary_trie_ip_lookup.sv
// ----------------------------------------------------------------------------
// binary_trie_ip_lookup
// Binary radix trie IPv4 lookup over one node store.
//
//   channel  signals                          word
//   in       in_valid / in_stall / in_word    write node or lookup address
//   out      out_valid / out_stall / out_word leaf value and not-found flag
//   cfg      cfg_we / cfg_index / cfg_data    leaf_base, record_bytes
//
// A write word is written into the node store as it is accepted. A lookup
// walks L levels (1 to ADDRESS_BITS) before its result is registered, since
// each level is one read of the node store through its single read port.
// Reset clears control and configuration and stalls the input; the node
// store is not cleared.
// Write words pass while a result waits; a lookup waits for the output.
// ----------------------------------------------------------------------------
module binary_trie_ip_lookup
  import btil_pkg::*;
#(
  parameter int NODE_INDEX_BITS = NODE_INDEX_BITS_DEF,
  parameter int ADDRESS_BITS    = ADDRESS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word
);

  cmd_t    cmd;
  status_t sts;

  btil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_opcode(in_word.opcode),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  btil_dp #(
    .NODE_INDEX_BITS(NODE_INDEX_BITS),
    .ADDRESS_BITS   (ADDRESS_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_word  (in_word),
    .out_word (out_word),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

FILE: design/btil_ram.sv
// ----------------------------------------------------------------------------
// btil_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module btil_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/btil_ctrl.sv
// ----------------------------------------------------------------------------
// btil_ctrl
// Controller: accepts words, sequences the trie walk, owns the output valid.
// ----------------------------------------------------------------------------
module btil_ctrl
  import btil_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_opcode,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    cmd,
  input  status_t sts
);

  state_t state, state_next;
  logic   accept;

  always_comb begin
    in_stall = rst || (state != ST_IDLE) || ((in_opcode == OP_LOOKUP) && out_valid);
    accept   = in_valid && !in_stall;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (in_opcode == OP_LOOKUP)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.walk_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.write_node = accept && (in_opcode == OP_WRITE);
        cmd.start      = accept && (in_opcode == OP_LOOKUP);
      end
      ST_WALK: begin
        cmd.walk   = 1'b1;
        cmd.finish = sts.walk_end;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/btil_dp.sv
// ----------------------------------------------------------------------------
// btil_dp
// Datapath: configuration registers, node store, walk registers and result.
// ----------------------------------------------------------------------------
module btil_dp
  import btil_pkg::*;
#(
  parameter int NODE_INDEX_BITS = NODE_INDEX_BITS_DEF,
  parameter int ADDRESS_BITS    = ADDRESS_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  in_word_t         in_word,
  output out_word_t        out_word,
  input  cmd_t             cmd,
  output status_t          sts
);

  localparam int NIB   = NODE_INDEX_BITS;
  localparam int LVL_W = $clog2(ADDRESS_BITS);

  logic [CFG_W-1:0]        leaf_base;
  logic [RECB_W-1:0]       record_bytes;
  logic [ADDRESS_BITS-1:0] addr_sr;
  logic [LVL_W-1:0]        level;
  logic [NIB+INDEX_W-1:0]  slot_wide;
  logic [NIB-1:0]          slot;
  logic [NIB-1:0]          raddr;
  logic [NODE_W-1:0]       wdata;
  logic [NODE_W-1:0]       rdata;
  logic [POINTER_W-1:0]    ptr;
  logic                    hit;
  logic                    beyond;

  function automatic logic [POINTER_W-1:0] cut_pointer(
    input logic [POINTER_W-1:0] p,
    input logic [RECB_W-1:0]    rb
  );
    logic [POINTER_W-1:0] v;
    v = p;
    if (rb < RECORD_BYTES_FULL) begin
      v[POINTER_W-1:24] = '0;
    end
    return v;
  endfunction

  always_comb begin
    slot_wide = {{NIB{1'b0}}, in_word.node_index};
    slot      = slot_wide[NIB-1:0];
    wdata     = {cut_pointer(in_word.right_pointer, record_bytes),
                 cut_pointer(in_word.left_pointer, record_bytes)};
    ptr       = addr_sr[ADDRESS_BITS-1] ? rdata[NODE_W-1:POINTER_W]
                                        : rdata[POINTER_W-1:0];
    hit       = ptr >= leaf_base;
    beyond    = ptr[POINTER_W-1:NIB] != '0;
    sts.walk_end = hit || beyond || (level == '0);
    raddr     = cmd.walk ? ptr[NIB-1:0] : '0;
  end

  btil_ram #(
    .WIDTH(NODE_W),
    .DEPTH(1 << NIB)
  ) u_store (
    .clk  (clk),
    .we   (cmd.write_node),
    .waddr(slot),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_base    <= LEAF_BASE_RESET;
      record_bytes <= RECORD_BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEAF_BASE:    leaf_base    <= cfg_data;
        CFG_RECORD_BYTES: record_bytes <= cfg_data[RECB_W-1:0];
        default:          leaf_base    <= leaf_base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_sr <= in_word.ip_address[ADDRESS_BITS-1:0];
      level   <= LVL_W'(ADDRESS_BITS - 1);
    end else if (cmd.walk) begin
      addr_sr <= {addr_sr[ADDRESS_BITS-2:0], 1'b0};
      level   <= level - 1'b1;
    end
    if (cmd.finish) begin
      out_word.leaf_value <= hit ? ptr : '0;
      out_word.not_found  <= !hit;
    end
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the binary trie IPv4 lookup block. Node writes and lookups
// are queued for a clocked driver. Each lookup result is predicted from a
// private copy of the node store and configuration, and a clocked monitor
// compares it with the result that comes out. The node store is only written
// through the block, and no lookup ever walks onto a slot that was never
// written. Several leaf_base and record_bytes settings are run, extremes
// included, under three patterns of idling on each side.
// ----------------------------------------------------------------------------
module tb_top;
  import btil_pkg::*;

  localparam int        NODES     = 1 << INDEX_W;
  localparam int        SETTLE    = 40;
  localparam int        PER_PHASE = 250;
  localparam int        PHASES    = 6;

  logic             clk;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = CFG_LEAF_BASE;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_word;

  logic [NODE_W-1:0]    trie_mem [0:NODES-1];
  bit                   trie_set [0:NODES-1];
  logic [CFG_W-1:0]     leaf_base_m = LEAF_BASE_RESET;
  logic [RECB_W-1:0]    rec_bytes_m = RECORD_BYTES_RESET;

  in_word_t  pending_words[$];
  out_word_t lookup_results[$];
  out_word_t want;

  int send_idle_pct = 17;
  int recv_idle_pct = 45;
  int fail_count    = 0;
  int nodes_written = 0;
  int lookups_sent  = 0;
  int misses_sent   = 0;
  int results_seen  = 0;

  binary_trie_ip_lookup u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [POINTER_W-1:0] clip_pointer(input logic [POINTER_W-1:0] p);
    if (rec_bytes_m >= RECORD_BYTES_FULL) return p;
    return {8'h00, p[23:0]};
  endfunction

  function automatic void walk_trie(input logic [IP_W-1:0] addr, output out_word_t res,
                                    output int gap);
    logic [POINTER_W-1:0] nd;
    logic [POINTER_W-1:0] p;
    int lvl;
    res.leaf_value = '0;
    res.not_found  = 1'b1;
    gap = -1;
    nd  = '0;
    for (lvl = IP_W - 1; lvl >= 0; lvl--) begin
      if (!trie_set[nd[INDEX_W-1:0]]) begin
        gap = int'(nd[INDEX_W-1:0]);
        return;
      end
      p = addr[lvl] ? trie_mem[nd[INDEX_W-1:0]][NODE_W-1:POINTER_W]
                    : trie_mem[nd[INDEX_W-1:0]][POINTER_W-1:0];
      if (p >= leaf_base_m) begin
        res.leaf_value = p;
        res.not_found  = 1'b0;
        return;
      end
      if (p >= NODES) return;
      nd = p;
    end
  endfunction

  function automatic logic [POINTER_W-1:0] pick_pointer();
    logic [POINTER_W-1:0] lim;
    logic [POINTER_W-1:0] p;
    lim = (rec_bytes_m >= RECORD_BYTES_FULL) ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
    case ($urandom_range(9))
      0, 1, 2: begin
        if (leaf_base_m <= lim) begin
          p = $urandom_range(lim, leaf_base_m);
          if (rec_bytes_m < RECORD_BYTES_FULL) p[31:24] = 8'($urandom);
        end else begin
          p = $urandom;
        end
      end
      3, 4, 5, 6: p = $urandom_range(31);
      7:          p = $urandom_range(NODES - 1);
      8: begin
        if (leaf_base_m > NODES) p = $urandom_range(leaf_base_m - 1, NODES);
        else p = $urandom;
      end
      default:    p = $urandom;
    endcase
    return p;
  endfunction

  task automatic issue_node(input logic [INDEX_W-1:0] idx, input logic [POINTER_W-1:0] lp,
                            input logic [POINTER_W-1:0] rp);
    in_word_t w;
    w.opcode        = OP_WRITE;
    w.node_index    = idx;
    w.left_pointer  = lp;
    w.right_pointer = rp;
    w.ip_address    = $urandom;
    trie_mem[idx]   = {clip_pointer(rp), clip_pointer(lp)};
    trie_set[idx]   = 1'b1;
    pending_words.push_back(w);
    nodes_written++;
  endtask

  task automatic issue_lookup(input logic [IP_W-1:0] addr);
    in_word_t  w;
    out_word_t res;
    int        gap;
    walk_trie(addr, res, gap);
    // fill any slot the walk would reach before it is written
    while (gap >= 0) begin
      issue_node(gap[INDEX_W-1:0], pick_pointer(), pick_pointer());
      walk_trie(addr, res, gap);
    end
    w.opcode        = OP_LOOKUP;
    w.node_index    = INDEX_W'($urandom);
    w.left_pointer  = $urandom;
    w.right_pointer = $urandom;
    w.ip_address    = addr;
    pending_words.push_back(w);
    lookup_results.push_back(res);
    lookups_sent++;
    if (res.not_found) misses_sent++;
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || lookup_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_LEAF_BASE) leaf_base_m = val;
    else rec_bytes_m = val[RECB_W-1:0];
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_word  <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (lookup_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: leaf %h not_found %0b",
                     out_word.leaf_value, out_word.not_found);
        end else begin
          want = lookup_results.pop_front();
          if (out_word.leaf_value !== want.leaf_value || out_word.not_found !== want.not_found)
          begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected leaf %h not_found %0b, got leaf %h not_found %0b",
                       want.leaf_value, want.not_found,
                       out_word.leaf_value, out_word.not_found);
          end
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0]  lb_set [PHASES];
    logic [RECB_W-1:0] rb_set [PHASES];
    int ph;
    int k;

    lb_set[0] = 32'h00FF_FF00;  rb_set[0] = RECORD_BYTES_FULL;
    lb_set[1] = 32'h0000_0000;  rb_set[1] = RECORD_BYTES_RESET;
    lb_set[2] = 32'hFFFF_FFFF;  rb_set[2] = RECORD_BYTES_FULL;
    lb_set[3] = NODES;          rb_set[3] = RECORD_BYTES_RESET;
    lb_set[4] = $urandom_range(32'h0100_0000, 32'h0000_0100);
    rb_set[4] = RECB_W'($urandom_range(RECORD_BYTES_FULL, RECORD_BYTES_RESET));
    lb_set[5] = LEAF_BASE_RESET; rb_set[5] = RECORD_BYTES_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // hand-built trie under the reset configuration
    issue_node(INDEX_W'(0), 32'd1, 32'd2);
    issue_node(INDEX_W'(1), 32'h00FF_FF00, 32'hABFF_FF05);
    issue_node(INDEX_W'(2), NODES, NODES - 1);
    issue_node(INDEX_W'(NODES - 1), 32'hFFFF_FFFF, 32'd3);
    issue_node(INDEX_W'(3), 32'd3, 32'd3);
    issue_node(INDEX_W'(4), 32'h00FF_FEFF, 32'h0000_0000);
    issue_lookup(32'h0000_0000);
    issue_lookup(32'h4000_0000);
    issue_lookup(32'h8000_0000);
    issue_lookup(32'hC000_0000);
    issue_lookup(32'hE000_0000);
    issue_lookup(32'hFFFF_FFFF);
    issue_lookup(32'h7FFF_FFFF);
    issue_node(INDEX_W'(3), 32'd4, 32'd3);
    issue_lookup(32'hE000_0000);
    issue_lookup(32'hF000_0000);
    issue_lookup(32'hE800_0000);
    issue_node(INDEX_W'(NODES - 1), 32'h00FF_FFFF, 32'hFFFF_FFFF);
    issue_lookup(32'hC000_0000);
    issue_lookup(32'hE000_0000);
    issue_lookup($urandom);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_reg(CFG_LEAF_BASE, lb_set[ph]);
      write_reg(CFG_RECORD_BYTES, {{(CFG_W-RECB_W){1'b0}}, rb_set[ph]});
      @(negedge clk);
      if (ph < 2) begin
        send_idle_pct = 17;
        recv_idle_pct = 45;
      end else if (ph < 4) begin
        send_idle_pct = 45;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (k = 0; k < PER_PHASE; k++) begin
        if ($urandom_range(9) < 4) begin
          if ($urandom_range(9) == 0) issue_node(INDEX_W'($urandom_range(NODES - 1)),
                                                 pick_pointer(), pick_pointer());
          else issue_node(INDEX_W'($urandom_range(31)), pick_pointer(), pick_pointer());
        end else begin
          issue_lookup($urandom);
        end
      end
    end

    wait_drained();
    if (lookup_results.size() != 0) fail_count += lookup_results.size();
    $display("Checked %0d lookup results (%0d not found) after %0d node writes,",
             results_seen, misses_sent, nodes_written);
    $display("over %0d leaf_base and record width settings and three idle patterns.",
             PHASES + 1);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
